>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("never violated");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/bblru_pkg.sv
// package for the byte budget lru cache: types, codes and sizes
package bblru_pkg;
  localparam int unsigned Slots    = 16;
  localparam int unsigned SizeBits = 40;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned CntW     = $clog2(Slots + 1);
  localparam int unsigned QDepth   = 2;
  localparam logic [SizeBits-1:0] CapReset = SizeBits'(1048576);
  localparam logic [7:0] PinMax = 8'd255;

  typedef enum logic [2:0] {
    REQ_ADMIT = 3'd0, REQ_TOUCH = 3'd1, REQ_PIN = 3'd2, REQ_UNPIN = 3'd3,
    REQ_ERASE = 3'd4, REQ_PROBE = 3'd5, REQ_RSV6 = 3'd6, REQ_RSV7 = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_TOO_LARGE = 3'd1, ST_ALL_PINNED = 3'd2, ST_MISSING = 3'd3,
    ST_PIN_UNDER = 3'd4, ST_ERASE_PINNED = 3'd5, ST_PIN_OVER = 3'd6, ST_RSV = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_VICTIM, BK_EVICT, BK_APPLY, BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [15:0]         entry_id;
    logic [SizeBits-1:0] entry_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]          status;
    logic                hit;
    logic                evicted_valid;
    logic [15:0]         evicted_id;
    logic [SizeBits-1:0] used_bytes;
    logic                last;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    req_e                op;
    logic [15:0]         id;
    logic [SizeBits-1:0] bytes;
    logic                too_large;
  } cmd_t;
endpackage

>>> hw/rtl/bblru_front.sv
// front end: accepts requests, decodes and prechecks them into a command queue
module bblru_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_stall_o,
  input  bblru_pkg::req_t               req_i,
  input  logic [bblru_pkg::SizeBits-1:0] cap_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i,
  output bblru_pkg::cmd_t               cmd_o
);
  import bblru_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t            q_mem [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;
  cmd_t            cmd_new;

  assign req_stall_o = (cnt_q == (PtrW+1)'(QDepth));
  assign push        = req_valid_i && !req_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  always_comb begin
    cmd_new.op        = req_e'(req_i.req_type);
    cmd_new.id        = req_i.entry_id;
    cmd_new.bytes     = req_i.entry_bytes;
    cmd_new.too_large = (req_i.entry_bytes > cap_i);
  end

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = cmd_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= cmd_new;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, cnt_q > (PtrW+1)'(QDepth))
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_pop_i && !cmd_valid_o)
  `ASSERT_IMPL(a_cnt_track, clk_i, rst_ni, (push && !cmd_pop_i) |=> cnt_q == $past(cnt_q) + 1'b1)
endmodule

>>> hw/rtl/bblru_back.sv
// back end: slot table, lookup and victim scans, evictions and result register
module bblru_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_pop_o,
  input  bblru_pkg::cmd_t                cmd_i,
  input  logic [bblru_pkg::SizeBits-1:0] cap_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_stall_i,
  output bblru_pkg::rsp_t                rsp_o
);
  import bblru_pkg::*;
  `include "assert_macros.svh"

  logic                slot_valid_q [Slots];
  logic [15:0]         slot_id_q    [Slots];
  logic [SizeBits-1:0] slot_size_q  [Slots];
  logic [7:0]          slot_pins_q  [Slots];
  logic [SlotW-1:0]    slot_rank_q  [Slots];
  logic [SizeBits-1:0] used_q;
  logic [CntW-1:0]     nvalid_q;

  bk_state_e state_q, state_d;
  cmd_t      cmd_q;
  logic [SlotW-1:0] idx_q;
  logic             found_q;
  logic [SlotW-1:0] fslot_q;
  logic             vic_ok_q;
  logic [SlotW-1:0] vic_q;
  logic             free_ok_q;
  logic [SlotW-1:0] free_q;
  logic             scan_last;
  rsp_t             rsp_q;
  logic             rsp_v_q;
  logic             out_free;
  logic             rsp_load_state;

  // one slot per cycle through the shared comparator
  logic   match_here, cand_here, better;
  logic [SizeBits:0] need_sum;
  logic   must_evict;

  assign out_free   = !rsp_v_q || !rsp_stall_i;
  assign scan_last  = (idx_q == SlotW'(Slots - 1));
  assign match_here = slot_valid_q[idx_q] && (slot_id_q[idx_q] == cmd_q.id);
  assign cand_here  = slot_valid_q[idx_q] && (slot_pins_q[idx_q] == 8'd0);
  assign better     = !vic_ok_q || (slot_rank_q[idx_q] < slot_rank_q[vic_q]);
  assign need_sum   = {1'b0, used_q} + {1'b0, cmd_q.bytes};
  assign must_evict = (need_sum > {1'b0, cap_i}) || (nvalid_q >= CntW'(Slots));
  assign cmd_pop_o  = (state_q == BK_IDLE) && cmd_valid_i;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;
  assign rsp_load_state = (state_q == BK_OUT) || (state_q == BK_EVICT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (cmd_valid_i) state_d = BK_SCAN;
      BK_SCAN:   if (scan_last) state_d = BK_APPLY;
      BK_VICTIM: if (scan_last) state_d = BK_EVICT;
      BK_EVICT:  if (out_free) state_d = vic_ok_q ? BK_APPLY : BK_IDLE;
      BK_APPLY: begin
        if (cmd_q.op == REQ_ADMIT && !cmd_q.too_large && !found_q && must_evict)
          state_d = BK_VICTIM;
        else if (out_free)
          state_d = BK_OUT;
      end
      BK_OUT:    if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // scan registers and slot table updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) slot_valid_q[i] <= 1'b0;
      used_q   <= '0;
      nvalid_q <= '0;
      rsp_v_q  <= 1'b0;
    end else begin
      if (rsp_v_q && !rsp_stall_i) rsp_v_q <= 1'b0;
      unique case (state_q)
        BK_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i; idx_q <= '0;
            found_q <= 1'b0; vic_ok_q <= 1'b0; free_ok_q <= 1'b0;
          end
        end
        BK_SCAN: begin
          if (match_here) begin found_q <= 1'b1; fslot_q <= idx_q; end
          if (!slot_valid_q[idx_q] && !free_ok_q) begin
            free_ok_q <= 1'b1; free_q <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
        end
        BK_VICTIM: begin
          if (cand_here && better) begin vic_ok_q <= 1'b1; vic_q <= idx_q; end
          idx_q <= idx_q + 1'b1;
        end
        BK_EVICT: begin
          if (out_free) begin
            rsp_v_q <= 1'b1;
            rsp_q.hit <= 1'b0;
            if (vic_ok_q) begin
              slot_valid_q[vic_q] <= 1'b0;
              for (int i = 0; i < Slots; i++)
                if (slot_valid_q[i] && slot_rank_q[i] > slot_rank_q[vic_q])
                  slot_rank_q[i] <= slot_rank_q[i] - 1'b1;
              used_q   <= used_q - slot_size_q[vic_q];
              nvalid_q <= nvalid_q - 1'b1;
              free_ok_q <= 1'b1; free_q <= vic_q;
              rsp_q.status <= ST_OK; rsp_q.evicted_valid <= 1'b1;
              rsp_q.evicted_id <= slot_id_q[vic_q];
              rsp_q.used_bytes <= used_q - slot_size_q[vic_q];
              rsp_q.last <= 1'b0;
              vic_ok_q <= 1'b0; idx_q <= '0;
            end else begin
              rsp_q.status <= ST_ALL_PINNED; rsp_q.evicted_valid <= 1'b0;
              rsp_q.evicted_id <= '0; rsp_q.used_bytes <= used_q;
              rsp_q.last <= 1'b1;
            end
          end
        end
        BK_APPLY: begin
          // settle the outcome; a fitting admit after evictions comes back here too
          if (cmd_q.op == REQ_ADMIT && !cmd_q.too_large && !found_q && must_evict) begin
            idx_q <= '0; vic_ok_q <= 1'b0;
          end else if (out_free) begin
            rsp_q.evicted_valid <= 1'b0; rsp_q.evicted_id <= '0; rsp_q.last <= 1'b1;
            rsp_q.hit <= 1'b0; rsp_q.status <= ST_OK;
            rsp_q.used_bytes <= used_q;
            priority case (1'b1)
              (cmd_q.op == REQ_ADMIT): begin
                if (cmd_q.too_large) begin
                  rsp_q.status <= ST_TOO_LARGE;
                end else if (found_q) begin
                  rsp_q.hit <= 1'b1;
                  for (int i = 0; i < Slots; i++)
                    if (slot_valid_q[i] && slot_rank_q[i] > slot_rank_q[fslot_q])
                      slot_rank_q[i] <= slot_rank_q[i] - 1'b1;
                  slot_rank_q[fslot_q] <= SlotW'(nvalid_q - 1'b1);
                end else begin
                  slot_valid_q[free_q] <= 1'b1;
                  slot_id_q[free_q]    <= cmd_q.id;
                  slot_size_q[free_q]  <= cmd_q.bytes;
                  slot_pins_q[free_q]  <= 8'd0;
                  slot_rank_q[free_q]  <= SlotW'(nvalid_q);
                  nvalid_q <= nvalid_q + 1'b1;
                  used_q   <= used_q + cmd_q.bytes;
                  rsp_q.used_bytes <= used_q + cmd_q.bytes;
                end
              end
              (cmd_q.op == REQ_PROBE): rsp_q.hit <= found_q;
              (cmd_q.op == REQ_RSV6 || cmd_q.op == REQ_RSV7): rsp_q.status <= ST_OK;
              (!found_q): rsp_q.status <= (cmd_q.op == REQ_ERASE) ? ST_OK : ST_MISSING;
              (cmd_q.op == REQ_TOUCH || cmd_q.op == REQ_PIN): begin
                rsp_q.hit <= 1'b1;
                if (cmd_q.op == REQ_PIN && slot_pins_q[fslot_q] == PinMax) begin
                  rsp_q.status <= ST_PIN_OVER;
                end else begin
                  if (cmd_q.op == REQ_PIN)
                    slot_pins_q[fslot_q] <= slot_pins_q[fslot_q] + 1'b1;
                  for (int i = 0; i < Slots; i++)
                    if (slot_valid_q[i] && slot_rank_q[i] > slot_rank_q[fslot_q])
                      slot_rank_q[i] <= slot_rank_q[i] - 1'b1;
                  slot_rank_q[fslot_q] <= SlotW'(nvalid_q - 1'b1);
                end
              end
              (cmd_q.op == REQ_UNPIN): begin
                rsp_q.hit <= 1'b1;
                if (slot_pins_q[fslot_q] == 8'd0) rsp_q.status <= ST_PIN_UNDER;
                else slot_pins_q[fslot_q] <= slot_pins_q[fslot_q] - 1'b1;
              end
              default: begin
                rsp_q.hit <= 1'b1;
                if (slot_pins_q[fslot_q] != 8'd0) begin
                  rsp_q.status <= ST_ERASE_PINNED;
                end else begin
                  slot_valid_q[fslot_q] <= 1'b0;
                  for (int i = 0; i < Slots; i++)
                    if (slot_valid_q[i] && slot_rank_q[i] > slot_rank_q[fslot_q])
                      slot_rank_q[i] <= slot_rank_q[i] - 1'b1;
                  used_q   <= used_q - slot_size_q[fslot_q];
                  nvalid_q <= nvalid_q - 1'b1;
                  rsp_q.used_bytes <= used_q - slot_size_q[fslot_q];
                end
              end
            endcase
          end
        end
        BK_OUT: if (out_free) rsp_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_pop_only_idle, clk_i, rst_ni, cmd_pop_o && state_q != BK_IDLE)
  `ASSERT_NEVER(a_nvalid_range, clk_i, rst_ni, nvalid_q > CntW'(Slots))
  `ASSERT_IMPL(a_out_from_out, clk_i, rst_ni, $rose(rsp_v_q) |-> $past(rsp_load_state))
endmodule

>>> hw/rtl/byte_budget_lru_cache_with_pins.sv
// top level: byte budget lru cache with pinning, front decode and back engine
// a request passes pop, 16-slot lookup scan, apply and the result register; output stalls add delay
// each eviction adds apply, a 16-slot victim scan and the evict step
// the back end takes a new request only once the last is done, its 16-slot scans going through one comparator
// reset: slots invalid, used bytes zero, capacity 1048576, command queue empty
// the two-entry command queue lets the front take requests while the back works
module byte_budget_lru_cache_with_pins (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bblru_pkg::SizeBits-1:0] cfg_wdata_i,
  input  logic                           req_valid_i,
  output logic                           req_stall_o,
  input  bblru_pkg::req_t                req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_stall_i,
  output bblru_pkg::rsp_t                rsp_o
);
  import bblru_pkg::*;

  logic [SizeBits-1:0] cap_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // capacity register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       cap_q <= CapReset;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  // front: transfer into the command queue with the size precheck
  bblru_front u_front (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_i,
    .cap_i(cap_q), .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  // back: scans, evictions, result register
  bblru_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .cap_i(cap_q), .rsp_valid_o, .rsp_stall_i, .rsp_o
  );
endmodule

>>> sim/byte_budget_lru_cache_with_pins_tb.sv
// testbench for the byte budget lru cache: random and directed requests checked against a predictor
module byte_budget_lru_cache_with_pins_tb;
  import bblru_pkg::*;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned NumRandom = 190;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [SizeBits-1:0] cfg_wdata;
  logic                req_valid;
  logic                req_stall;
  req_t                req;
  logic                rsp_valid;
  logic                rsp_stall;
  rsp_t                rsp;

  byte_budget_lru_cache_with_pins i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp)
  );

  // clock with period 12
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shadow of the cache state
  logic [SizeBits-1:0] cap_q;
  logic                sh_valid [Slots];
  logic [15:0]         sh_id    [Slots];
  logic [SizeBits-1:0] sh_size  [Slots];
  logic [7:0]          sh_pins  [Slots];
  int unsigned         sh_rank  [Slots];
  logic [SizeBits-1:0] sh_used;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned n_fail, n_rsp, n_evict;
  bit stim_done;

  function automatic int lookup(logic [15:0] id);
    for (int i = 0; i < Slots; i++) if (sh_valid[i] && sh_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int unsigned resident_count();
    int unsigned n = 0;
    for (int i = 0; i < Slots; i++) if (sh_valid[i]) n++;
    return n;
  endfunction

  function automatic void close_gap(int unsigned r);
    for (int i = 0; i < Slots; i++) if (sh_valid[i] && sh_rank[i] > r) sh_rank[i]--;
  endfunction

  function automatic void make_recent(int s);
    close_gap(sh_rank[s]);
    sh_rank[s] = resident_count() - 1;
  endfunction

  function automatic void drop(int s);
    sh_valid[s] = 1'b0;
    close_gap(sh_rank[s]);
    sh_used = sh_used - sh_size[s];
  endfunction

  function automatic void queue_rsp(status_e st, logic h, logic ev, logic [15:0] evid,
                                    logic lst);
    rsp_t r;
    r.status        = st;
    r.hit           = h;
    r.evicted_valid = ev;
    r.evicted_id    = evid;
    r.used_bytes    = sh_used;
    r.last          = lst;
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  // work out the responses of one accepted request and update the shadow
  function automatic void predict_cache(req_t r);
    int s, victim;
    logic [SizeBits:0] need;
    s = lookup(r.entry_id);
    case (req_e'(r.req_type))
      REQ_ADMIT: begin
        if (r.entry_bytes > cap_q) begin
          queue_rsp(ST_TOO_LARGE, 1'b0, 1'b0, 16'd0, 1'b1);
        end else if (s >= 0) begin
          make_recent(s);
          queue_rsp(ST_OK, 1'b1, 1'b0, 16'd0, 1'b1);
        end else begin
          forever begin
            need = {1'b0, sh_used} + {1'b0, r.entry_bytes};
            if (need <= {1'b0, cap_q} && resident_count() < Slots) break;
            victim = -1;
            for (int i = 0; i < Slots; i++)
              if (sh_valid[i] && sh_pins[i] == 0 &&
                  (victim < 0 || sh_rank[i] < sh_rank[victim])) victim = i;
            if (victim < 0) begin
              queue_rsp(ST_ALL_PINNED, 1'b0, 1'b0, 16'd0, 1'b1);
              return;
            end
            drop(victim);
            queue_rsp(ST_OK, 1'b0, 1'b1, sh_id[victim], 1'b0);
          end
          for (int i = 0; i < Slots; i++) begin
            if (!sh_valid[i]) begin
              sh_rank[i]  = resident_count();
              sh_valid[i] = 1'b1;
              sh_id[i]    = r.entry_id;
              sh_size[i]  = r.entry_bytes;
              sh_pins[i]  = 8'd0;
              sh_used     = sh_used + r.entry_bytes;
              break;
            end
          end
          queue_rsp(ST_OK, 1'b0, 1'b0, 16'd0, 1'b1);
        end
      end
      REQ_PROBE: queue_rsp(ST_OK, s >= 0, 1'b0, 16'd0, 1'b1);
      REQ_TOUCH, REQ_PIN, REQ_UNPIN, REQ_ERASE: begin
        if (s < 0) begin
          queue_rsp(r.req_type == REQ_ERASE ? ST_OK : ST_MISSING, 1'b0, 1'b0, 16'd0, 1'b1);
        end else if (r.req_type == REQ_TOUCH) begin
          make_recent(s);
          queue_rsp(ST_OK, 1'b1, 1'b0, 16'd0, 1'b1);
        end else if (r.req_type == REQ_PIN) begin
          if (sh_pins[s] == PinMax) queue_rsp(ST_PIN_OVER, 1'b1, 1'b0, 16'd0, 1'b1);
          else begin
            sh_pins[s]++;
            make_recent(s);
            queue_rsp(ST_OK, 1'b1, 1'b0, 16'd0, 1'b1);
          end
        end else if (r.req_type == REQ_UNPIN) begin
          if (sh_pins[s] == 0) queue_rsp(ST_PIN_UNDER, 1'b1, 1'b0, 16'd0, 1'b1);
          else begin
            sh_pins[s]--;
            queue_rsp(ST_OK, 1'b1, 1'b0, 16'd0, 1'b1);
          end
        end else begin
          if (sh_pins[s] != 0) queue_rsp(ST_ERASE_PINNED, 1'b1, 1'b0, 16'd0, 1'b1);
          else begin
            drop(s);
            queue_rsp(ST_OK, 1'b1, 1'b0, 16'd0, 1'b1);
          end
        end
      end
      default: queue_rsp(ST_OK, 1'b0, 1'b0, 16'd0, 1'b1);
    endcase
  endfunction

  // driver: bursts of transfers separated by random gaps
  int unsigned burst_left, gap_left;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid  <= 1'b0;
      req        <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (req_valid && !req_stall) predict_cache(req);
      if (!req_valid || !req_stall) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            // some bursts run with no gap after them
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: phases of no stall, light and heavy stall
  int unsigned stall_phase;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_stall   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 3)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response transfer %p", rsp);
        n_fail++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        n_rsp++;
        if (rsp.evicted_valid) n_evict++;
        if (rsp.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, rsp.status); n_fail++;
        end
        if (rsp.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, rsp.hit); n_fail++;
        end
        if (rsp.evicted_valid !== e.evicted_valid) begin
          $error("evicted_valid: expected %0d, got %0d", e.evicted_valid,
                 rsp.evicted_valid); n_fail++;
        end
        if (rsp.evicted_id !== e.evicted_id) begin
          $error("evicted_id: expected %0d, got %0d", e.evicted_id, rsp.evicted_id);
          n_fail++;
        end
        if (rsp.used_bytes !== e.used_bytes) begin
          $error("used_bytes: expected %0d, got %0d", e.used_bytes, rsp.used_bytes);
          n_fail++;
        end
        if (rsp.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, rsp.last); n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else if (rst_n && !stim_done && (pending_reqs.size() != 0 || expected_rsps.size() != 0 ||
             req_valid)) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired, %0d responses outstanding", expected_rsps.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_req(req_e op, logic [15:0] id, logic [SizeBits-1:0] nbytes);
    req_t r;
    r.req_type    = op;
    r.entry_id    = id;
    r.entry_bytes = nbytes;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // let everything queued drain, then allow the back end to settle
  task automatic drain();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_capacity(logic [SizeBits-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_q      = val;
    @(posedge clk);
  endtask

  // random mix: ids from a small pool so hits, pins and evictions are common
  task automatic random_phase(int unsigned n, int unsigned max_bytes_log);
    logic [15:0] id;
    logic [SizeBits-1:0] nb;
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
      nb = SizeBits'({$urandom, $urandom} >> (64 - $urandom_range(1, max_bytes_log)));
      if ($urandom_range(0, 40) == 0) nb = SizeBits'({$urandom, $urandom});
      if (pick < 40)      add_req(REQ_ADMIT, id, nb);
      else if (pick < 52) add_req(REQ_TOUCH, id, nb);
      else if (pick < 64) add_req(REQ_PIN, id, nb);
      else if (pick < 78) add_req(REQ_UNPIN, id, nb);
      else if (pick < 88) add_req(REQ_ERASE, id, nb);
      else if (pick < 97) add_req(REQ_PROBE, id, nb);
      else add_req(req_e'($urandom_range(6, 7)), id, nb);
    end
  endtask

  initial begin
    cap_q       = CapReset;
    sh_used     = '0;
    n_fail      = 0;
    n_rsp       = 0;
    n_evict     = 0;
    stim_done   = 0;
    idle_cycles = 0;
    for (int i = 0; i < Slots; i++) begin
      sh_valid[i] = 0; sh_id[i] = 0; sh_size[i] = 0; sh_pins[i] = 0; sh_rank[i] = 0;
    end
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: too large, fills, resident admit, misses, pin and erase cases
    add_req(REQ_ADMIT, 16'hFFFF, {SizeBits{1'b1}});
    add_req(REQ_ADMIT, 16'h0000, 40'd0);
    add_req(REQ_ADMIT, 16'hFFFF, 40'd1048576);
    add_req(REQ_ADMIT, 16'h0000, 40'd5);
    add_req(REQ_TOUCH, 16'h1234, 40'd0);
    add_req(REQ_PIN, 16'h1234, 40'd0);
    add_req(REQ_UNPIN, 16'h1234, 40'd0);
    add_req(REQ_ERASE, 16'h1234, 40'd0);
    add_req(REQ_PROBE, 16'h0000, 40'd0);
    add_req(REQ_UNPIN, 16'h0000, 40'd0);
    add_req(REQ_PIN, 16'h0000, 40'd0);
    add_req(REQ_ERASE, 16'h0000, 40'd0);
    add_req(REQ_RSV6, 16'h0000, 40'd0);
    add_req(REQ_RSV7, 16'hFFFF, {SizeBits{1'b1}});
    add_req(REQ_ADMIT, 16'h0001, 40'd16);  // evicts id ffff, the only unpinned entry
    add_req(REQ_UNPIN, 16'h0000, 40'd0);
    add_req(REQ_ERASE, 16'hFFFF, 40'd0);
    add_req(REQ_PROBE, 16'hFFFF, 40'd0);
    // full table: seventeen small admits force slot evictions
    for (int k = 0; k < 17; k++) add_req(REQ_ADMIT, 16'(100 + k), 40'd1);
    drain();

    // small capacity so byte pressure drives eviction chains
    write_capacity(40'd1);
    random_phase(20, 2);
    write_capacity(40'd64);
    random_phase(50, 7);
    // capacity lowered below current use
    write_capacity(40'd20);
    random_phase(40, 5);
    write_capacity({SizeBits{1'b1}});
    random_phase(40, 40);
    write_capacity(40'd1048576);
    random_phase(NumRandom - 150, 21);
    // pin overflow on id 7, left pinned as this is the last phase
    add_req(REQ_ADMIT, 16'h0007, 40'd1);
    for (int k = 0; k < 256; k++) add_req(REQ_PIN, 16'h0007, 40'd0);
    add_req(REQ_UNPIN, 16'h0007, 40'd0);
    drain();
    stim_done = 1;

    $display("covered %0d responses, %0d evictions, across six capacity settings",
             n_rsp, n_evict);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bblru_pkg.sv
hw/rtl/bblru_front.sv
hw/rtl/bblru_back.sv
hw/rtl/byte_budget_lru_cache_with_pins.sv
sim/byte_budget_lru_cache_with_pins_tb.sv
